[rtl/ntcs_pkg.sv]
// ----------------------------------------------------------------------------
// ntcs_pkg
// Shared types, constants and the thermistor curve for the sample-to-Celsius
// search block.
// ----------------------------------------------------------------------------
package ntcs_pkg;

  localparam int ADC_W        = 16;
  localparam int TEMP_W       = 9;
  localparam int START_TEMP   = 64;
  localparam int INITIAL_STEP = 64;
  localparam int STEP_W       = $clog2(INITIAL_STEP) + 1;
  localparam int T_W          = 11;
  localparam int T_MIN        = START_TEMP - 2 * INITIAL_STEP;
  localparam int T_MAX        = START_TEMP + 2 * INITIAL_STEP;
  localparam int OUT_MIN      = -256;
  localparam int OUT_MAX      = 255;

  localparam int SEG_DEG  = 10;
  localparam int ZERO_IDX = 5;
  localparam int LAST_IDX = 20;

  localparam int M_W       = T_W - 1;
  localparam int IDX_W     = 6;
  localparam int TI_W      = 5;
  localparam int CURVE_W   = 17;
  localparam int DLT_W     = CURVE_W + 1;
  localparam int NUM_W     = 24;
  localparam int MAG_W     = NUM_W - 1;
  localparam int E_W       = MAG_W + 1;
  localparam int OP_W      = 24;
  localparam int PROD_W    = 2 * OP_W;
  localparam int IDX_SHIFT = 11;
  localparam int IDX_RECIP = 205;
  localparam int DIV_SHIFT = 25;
  localparam int DIV_RECIP = 3355444;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_NUM,
    ST_DIV,
    ST_CMP,
    ST_FIN
  } ntcs_state_e;

  typedef enum logic [1:0] {
    OP_IDX,
    OP_NUM,
    OP_DIV
  } ntcs_op_e;

  typedef struct packed {
    logic                      en;
    ntcs_op_e                  op;
    logic [M_W-1:0]            m;
    logic [M_W-1:0]            o;
    logic signed [DLT_W-1:0]   dlt;
    logic [MAG_W-1:0]          mag;
  } ntcs_mul_req_t;

  function automatic logic signed [CURVE_W-1:0] curve(input logic [TI_W-1:0] idx);
    logic signed [CURVE_W-1:0] v;
    case (idx)
      5'd0:    v = 17'sd98;
      5'd1:    v = 17'sd194;
      5'd2:    v = 17'sd368;
      5'd3:    v = 17'sd668;
      5'd4:    v = 17'sd1163;
      5'd5:    v = 17'sd1948;
      5'd6:    v = 17'sd3136;
      5'd7:    v = 17'sd4858;
      5'd8:    v = 17'sd7236;
      5'd9:    v = 17'sd10358;
      5'd10:   v = 17'sd14238;
      5'd11:   v = 17'sd18789;
      5'd12:   v = 17'sd23814;
      5'd13:   v = 17'sd29024;
      5'd14:   v = 17'sd34174;
      5'd15:   v = 17'sd39010;
      5'd16:   v = 17'sd43367;
      5'd17:   v = 17'sd48845;
      5'd18:   v = 17'sd50377;
      5'd19:   v = 17'sd51791;
      5'd20:   v = 17'sd55291;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/ntcs_if.sv]
// ----------------------------------------------------------------------------
// ntcs_if
// Valid/ready channels for ADC samples and Celsius results.
// ----------------------------------------------------------------------------
interface ntcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [ntcs_pkg::ADC_W-1:0]     adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ntcs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ntcs_pkg::TEMP_W-1:0] temperature_c;

  modport source (output valid, output temperature_c, input ready);
  modport sink   (input valid, input temperature_c, output ready);
endinterface

[rtl/ntc_adc_to_celsius_search.sv]
// ----------------------------------------------------------------------------
// ntc_adc_to_celsius_search
// Converts a thermistor ADC word to whole degrees Celsius by halving search
// over an interpolated 21-point curve.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload               Width
//  in_i     in   adc_sample            16 unsigned
//  out_o    out  temperature_c         9 signed
//
//  Each search step uses the shared multiplier for the segment index, the
//  interpolation product and the division by ten, then compares and updates.
//  A word runs eight steps plus an accept in the idle state and a write-out
//  state, fewer steps when an exact match ends the search early.
//  The input is ready only while the sequencer is idle; a result waiting in
//  the output register stalls only write-out. Reset clears control state.
// ----------------------------------------------------------------------------
module ntc_adc_to_celsius_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  ntcs_in_if.sink           in_i,
  ntcs_out_if.source        out_o
);

  ntcs_pkg::ntcs_state_e                state_q, state_d;
  logic [ntcs_pkg::ADC_W-1:0]           x_q, x_d;
  logic signed [ntcs_pkg::T_W-1:0]      t_q, t_d;
  logic [ntcs_pkg::STEP_W-1:0]          step_q, step_d;
  logic                                 final_q, final_d;
  logic                                 neg_q, neg_d;
  logic signed [ntcs_pkg::NUM_W-1:0]    base_q, base_d;
  logic                                 ovalid_q, ovalid_d;
  logic signed [ntcs_pkg::TEMP_W-1:0]   temp_q, temp_d;

  ntcs_pkg::ntcs_mul_req_t              mreq;
  logic signed [ntcs_pkg::PROD_W-1:0]   prod;

  logic                                 t_neg;
  logic [ntcs_pkg::M_W-1:0]             m;
  logic [ntcs_pkg::IDX_W-1:0]           seg_raw;
  logic [ntcs_pkg::IDX_W-1:0]           seg_i;
  logic [ntcs_pkg::M_W-1:0]             seg_o;
  logic [ntcs_pkg::TI_W-1:0]            lo_idx, hi_idx;
  logic signed [ntcs_pkg::CURVE_W-1:0]  lo_v, hi_v;
  logic signed [ntcs_pkg::NUM_W-1:0]    num;
  logic [ntcs_pkg::MAG_W-1:0]           mag;
  logic [ntcs_pkg::MAG_W-1:0]           quo;
  logic signed [ntcs_pkg::E_W-1:0]      e_val, x_ext;
  logic signed [ntcs_pkg::T_W-1:0]      step_s;
  logic                                 in_fire;

  ntcs_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ntcs_pkg::ST_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.temperature_c = temp_q;

  always_comb begin
    t_neg   = t_q[ntcs_pkg::T_W-1];
    m       = t_neg ? ntcs_pkg::M_W'(-t_q) : ntcs_pkg::M_W'(t_q);
    seg_raw = prod[ntcs_pkg::IDX_SHIFT +: ntcs_pkg::IDX_W];
    seg_i   = seg_raw;
    seg_o   = m - ntcs_pkg::M_W'(seg_raw) * ntcs_pkg::M_W'(ntcs_pkg::SEG_DEG);
    if (t_neg) begin
      if (seg_raw >= ntcs_pkg::IDX_W'(ntcs_pkg::ZERO_IDX)) begin
        seg_i = ntcs_pkg::IDX_W'(ntcs_pkg::ZERO_IDX - 1);
        seg_o = m - ntcs_pkg::M_W'((ntcs_pkg::ZERO_IDX - 1) * ntcs_pkg::SEG_DEG);
      end
      lo_idx = ntcs_pkg::TI_W'(ntcs_pkg::ZERO_IDX) - ntcs_pkg::TI_W'(seg_i);
      hi_idx = lo_idx - ntcs_pkg::TI_W'(1);
    end else begin
      if (seg_raw >= ntcs_pkg::IDX_W'(ntcs_pkg::LAST_IDX - ntcs_pkg::ZERO_IDX)) begin
        seg_i = ntcs_pkg::IDX_W'(ntcs_pkg::LAST_IDX - ntcs_pkg::ZERO_IDX - 1);
        seg_o = m - ntcs_pkg::M_W'((ntcs_pkg::LAST_IDX - ntcs_pkg::ZERO_IDX - 1)
                                   * ntcs_pkg::SEG_DEG);
      end
      lo_idx = ntcs_pkg::TI_W'(ntcs_pkg::ZERO_IDX) + ntcs_pkg::TI_W'(seg_i);
      hi_idx = lo_idx + ntcs_pkg::TI_W'(1);
    end
    lo_v = ntcs_pkg::curve(lo_idx);
    hi_v = ntcs_pkg::curve(hi_idx);

    num = signed'(prod[ntcs_pkg::NUM_W-1:0]) + base_q;
    mag = num[ntcs_pkg::NUM_W-1] ? ntcs_pkg::MAG_W'(-num) : ntcs_pkg::MAG_W'(num);

    quo   = prod[ntcs_pkg::DIV_SHIFT +: ntcs_pkg::MAG_W];
    e_val = neg_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    x_ext = signed'(ntcs_pkg::E_W'(x_q));
    step_s = signed'(ntcs_pkg::T_W'(step_q));
  end

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    t_d      = t_q;
    step_d   = step_q;
    final_d  = final_q;
    neg_d    = neg_q;
    base_d   = base_q;
    ovalid_d = ovalid_q;
    temp_d   = temp_q;

    mreq.en  = 1'b0;
    mreq.op  = ntcs_pkg::OP_IDX;
    mreq.m   = m;
    mreq.o   = seg_o;
    mreq.dlt = ntcs_pkg::DLT_W'(hi_v) - ntcs_pkg::DLT_W'(lo_v);
    mreq.mag = mag;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ntcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_d     = in_i.adc_sample;
          t_d     = ntcs_pkg::T_W'(ntcs_pkg::START_TEMP);
          step_d  = ntcs_pkg::STEP_W'(ntcs_pkg::INITIAL_STEP);
          final_d = 1'b0;
          state_d = ntcs_pkg::ST_IDX;
        end
      end
      ntcs_pkg::ST_IDX: begin
        mreq.en = 1'b1;
        mreq.op = ntcs_pkg::OP_IDX;
        state_d = ntcs_pkg::ST_NUM;
      end
      ntcs_pkg::ST_NUM: begin
        mreq.en = 1'b1;
        mreq.op = ntcs_pkg::OP_NUM;
        base_d  = ntcs_pkg::NUM_W'(lo_v) * ntcs_pkg::NUM_W'(ntcs_pkg::SEG_DEG);
        state_d = ntcs_pkg::ST_DIV;
      end
      ntcs_pkg::ST_DIV: begin
        mreq.en = 1'b1;
        mreq.op = ntcs_pkg::OP_DIV;
        neg_d   = num[ntcs_pkg::NUM_W-1];
        state_d = ntcs_pkg::ST_CMP;
      end
      ntcs_pkg::ST_CMP: begin
        if (final_q) begin
          if (e_val < x_ext) begin
            t_d = t_q + ntcs_pkg::T_W'(1);
          end
          state_d = ntcs_pkg::ST_FIN;
        end else if (e_val == x_ext) begin
          state_d = ntcs_pkg::ST_FIN;
        end else begin
          if (e_val < x_ext) begin
            t_d = t_q + step_s;
          end else begin
            t_d = t_q - step_s;
          end
          if (step_q == ntcs_pkg::STEP_W'(1)) begin
            final_d = 1'b1;
          end else begin
            step_d = step_q >> 1;
          end
          state_d = ntcs_pkg::ST_IDX;
        end
      end
      ntcs_pkg::ST_FIN: begin
        if (!ovalid_q || out_o.ready) begin
          if (t_q < ntcs_pkg::OUT_MIN) begin
            temp_d = ntcs_pkg::TEMP_W'(ntcs_pkg::OUT_MIN);
          end else if (t_q > ntcs_pkg::OUT_MAX) begin
            temp_d = ntcs_pkg::TEMP_W'(ntcs_pkg::OUT_MAX);
          end else begin
            temp_d = ntcs_pkg::TEMP_W'(t_q);
          end
          ovalid_d = 1'b1;
          state_d  = ntcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ntcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ntcs_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    t_q     <= t_d;
    step_q  <= step_d;
    final_q <= final_d;
    neg_q   <= neg_d;
    base_q  <= base_d;
    temp_q  <= temp_d;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ntcs_pkg::ST_IDX && t_q == ntcs_pkg::START_TEMP)
    else $error("search did not start from the initial candidate");

  a_step_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntcs_pkg::ST_IDX || state_q == ntcs_pkg::ST_NUM ||
     state_q == ntcs_pkg::ST_DIV || state_q == ntcs_pkg::ST_CMP) |-> $onehot(step_q))
    else $error("search step is not a power of two");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ntcs_pkg::ST_IDLE) |-> (t_q >= ntcs_pkg::T_MIN && t_q <= ntcs_pkg::T_MAX))
    else $error("candidate temperature left its reachable range");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntcs_pkg::ST_CMP && final_q) |=> state_q == ntcs_pkg::ST_FIN)
    else $error("final correction did not end the search");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == ntcs_pkg::ST_FIN)
    else $error("result word loaded outside the write-out cycle");

endmodule

[rtl/ntcs_mul.sv]
// ----------------------------------------------------------------------------
// ntcs_mul
// Shared signed multiplier with registered product, used for segment
// indexing, interpolation and division by ten.
// ----------------------------------------------------------------------------
module ntcs_mul (
  input  logic                                  clk_i,
  input  ntcs_pkg::ntcs_mul_req_t               req_i,
  output logic signed [ntcs_pkg::PROD_W-1:0]    prod_o
);

  logic signed [ntcs_pkg::OP_W-1:0]   op_a;
  logic signed [ntcs_pkg::OP_W-1:0]   op_b;
  logic signed [ntcs_pkg::PROD_W-1:0] prod_d;
  logic signed [ntcs_pkg::PROD_W-1:0] prod_q;

  always_comb begin
    case (req_i.op)
      ntcs_pkg::OP_IDX: begin
        op_a = signed'(ntcs_pkg::OP_W'(req_i.m));
        op_b = ntcs_pkg::OP_W'(ntcs_pkg::IDX_RECIP);
      end
      ntcs_pkg::OP_NUM: begin
        op_a = ntcs_pkg::OP_W'(req_i.dlt);
        op_b = signed'(ntcs_pkg::OP_W'(req_i.o));
      end
      ntcs_pkg::OP_DIV: begin
        op_a = signed'(ntcs_pkg::OP_W'(req_i.mag));
        op_b = ntcs_pkg::OP_W'(ntcs_pkg::DIV_RECIP);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
